### rtl/core/ts_pat_pkg.sv
// Shared types, constants and helpers for the transport stream PAT section parser.
// No dependencies.
package ts_pat_pkg;

    localparam int          FifoDepth = 4;
    localparam int          FifoAw    = 2;
    localparam logic [11:0] MinLength = 12'd9;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_LEN_HI  = 4'd1,
        PH_LEN_LO  = 4'd2,
        PH_TSID_HI = 4'd3,
        PH_TSID_LO = 4'd4,
        PH_VER     = 4'd5,
        PH_SEC     = 4'd6,
        PH_LAST    = 4'd7,
        PH_ENTRY   = 4'd8,
        PH_CRC     = 4'd9
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NETWORK   = 3'd0,
        KIND_PROGRAM   = 3'd1,
        KIND_DONE      = 3'd2,
        KIND_BAD_TABLE = 3'd3,
        KIND_TRUNCATED = 3'd4,
        KIND_SHORT_LEN = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] program_number;
        logic [12:0] map_pid;
        logic [15:0] stream_id;
        logic [4:0]  version;
        logic        current_next;
        logic [7:0]  section_index;
        logic [7:0]  last_section_index;
        logic [31:0] crc_value;
        logic [9:0]  entry_total;
        logic        last_of_run;
    } result_t;

    function automatic logic [9:0] total_entries(input logic [11:0] len);
        logic [11:0] diff;
        diff = len - MinLength;
        if (len < MinLength)
            return 10'd0;
        return diff[11:2];
    endfunction

endpackage

### rtl/core/ts_pat_section_parser_core.sv
// PAT section parser: byte-wise field capture, entry/done/error results and result queue.
// Depends on ts_pat_pkg.
// Output: a result is visible on the output in the cycle after its byte is accepted when the
// result queue is empty; otherwise it waits behind the queued transactions.
// Throughput: one byte per cycle while in_stall is low; a byte yields up to two results,
// queued in a four-entry result queue that drains one transaction per cycle while
// out_stall is low. Input stalls while more than two results are queued.
// Reset: asynchronous, clears the parse state, header capture and the result queue.
module ts_pat_section_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        section_start,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  result_kind,
    output logic [15:0] program_number,
    output logic [12:0] map_pid,
    output logic [15:0] stream_id,
    output logic [4:0]  version,
    output logic        current_next,
    output logic [7:0]  section_index,
    output logic [7:0]  last_section_index,
    output logic [31:0] crc_value,
    output logic [9:0]  entry_total,
    output logic        last_of_run
);

    ts_pat_pkg::phase_t phase_reg, phase_next;
    logic [1:0]  byte_in_field_reg, byte_in_field_next;
    logic [9:0]  entries_left_reg, entries_left_next;
    logic [11:0] length_field_reg, length_field_next;
    logic [15:0] entry_program_reg, entry_program_next;
    logic [12:0] entry_pid_reg, entry_pid_next;
    logic [15:0] stream_id_reg, stream_id_next;
    logic [4:0]  version_reg, version_next;
    logic        current_bit_reg, current_bit_next;
    logic [7:0]  section_reg, section_next;
    logic [7:0]  last_section_reg, last_section_next;
    logic [31:0] crc_reg, crc_next;

    ts_pat_pkg::result_t fifo_reg [ts_pat_pkg::FifoDepth];
    logic [ts_pat_pkg::FifoAw-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ts_pat_pkg::FifoAw-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ts_pat_pkg::FifoAw:0]   count_reg, count_next;

    logic in_accept, pop;
    logic has_a, has_trunc, skip;
    ts_pat_pkg::kind_t kind_a;
    logic [15:0] prog_a;
    logic [12:0] pid_a;
    logic [31:0] crc_a;
    logic [9:0]  entries_dec;
    logic [1:0]  n_res;
    ts_pat_pkg::result_t base_res, res_a, res_t0, slot0, slot1;

    assign in_stall  = (count_reg > 3'd2);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = (count_reg != '0);
    assign pop       = out_valid && !out_stall;

    always_comb
    begin
        phase_next         = phase_reg;
        byte_in_field_next = byte_in_field_reg;
        entries_left_next  = entries_left_reg;
        length_field_next  = length_field_reg;
        entry_program_next = entry_program_reg;
        entry_pid_next     = entry_pid_reg;
        stream_id_next     = stream_id_reg;
        version_next       = version_reg;
        current_bit_next   = current_bit_reg;
        section_next       = section_reg;
        last_section_next  = last_section_reg;
        crc_next           = crc_reg;
        has_a              = 1'b0;
        kind_a             = ts_pat_pkg::KIND_DONE;
        prog_a             = 16'd0;
        pid_a              = 13'd0;
        crc_a              = 32'd0;
        skip               = 1'b0;
        entries_dec        = entries_left_reg - 10'd1;

        if (section_start)
        begin
            byte_in_field_next = 2'd0;
            entries_left_next  = 10'd0;
            length_field_next  = 12'd0;
            entry_program_next = 16'd0;
            entry_pid_next     = 13'd0;
            stream_id_next     = 16'd0;
            version_next       = 5'd0;
            current_bit_next   = 1'b0;
            section_next       = 8'd0;
            last_section_next  = 8'd0;
            crc_next           = 32'd0;
            if (data_byte != 8'd0)
            begin
                has_a      = 1'b1;
                kind_a     = ts_pat_pkg::KIND_BAD_TABLE;
                phase_next = ts_pat_pkg::PH_IDLE;
            end
            else
            begin
                phase_next = ts_pat_pkg::PH_LEN_HI;
            end
        end
        else
        begin
            case (phase_reg)
                ts_pat_pkg::PH_LEN_HI:
                begin
                    length_field_next = {data_byte[3:0], 8'd0};
                    phase_next        = ts_pat_pkg::PH_LEN_LO;
                end
                ts_pat_pkg::PH_LEN_LO:
                begin
                    length_field_next = {length_field_reg[11:8], data_byte};
                    if (length_field_next < ts_pat_pkg::MinLength)
                    begin
                        has_a      = 1'b1;
                        kind_a     = ts_pat_pkg::KIND_SHORT_LEN;
                        phase_next = ts_pat_pkg::PH_IDLE;
                    end
                    else
                    begin
                        entries_left_next = ts_pat_pkg::total_entries(length_field_next);
                        phase_next        = ts_pat_pkg::PH_TSID_HI;
                    end
                end
                ts_pat_pkg::PH_TSID_HI:
                begin
                    stream_id_next = {data_byte, 8'd0};
                    phase_next     = ts_pat_pkg::PH_TSID_LO;
                end
                ts_pat_pkg::PH_TSID_LO:
                begin
                    stream_id_next = {stream_id_reg[15:8], data_byte};
                    phase_next     = ts_pat_pkg::PH_VER;
                end
                ts_pat_pkg::PH_VER:
                begin
                    version_next     = data_byte[5:1];
                    current_bit_next = data_byte[0];
                    phase_next       = ts_pat_pkg::PH_SEC;
                end
                ts_pat_pkg::PH_SEC:
                begin
                    section_next = data_byte;
                    phase_next   = ts_pat_pkg::PH_LAST;
                end
                ts_pat_pkg::PH_LAST:
                begin
                    last_section_next  = data_byte;
                    byte_in_field_next = 2'd0;
                    phase_next = (entries_left_reg != 10'd0) ? ts_pat_pkg::PH_ENTRY
                                                             : ts_pat_pkg::PH_CRC;
                end
                ts_pat_pkg::PH_ENTRY:
                begin
                    case (byte_in_field_reg)
                        2'd0:    entry_program_next = {data_byte, 8'd0};
                        2'd1:    entry_program_next = {entry_program_reg[15:8], data_byte};
                        2'd2:    entry_pid_next     = {data_byte[4:0], 8'd0};
                        default:
                        begin
                            entry_pid_next    = {entry_pid_reg[12:8], data_byte};
                            has_a             = 1'b1;
                            kind_a = (entry_program_reg == 16'd0) ? ts_pat_pkg::KIND_NETWORK
                                                                  : ts_pat_pkg::KIND_PROGRAM;
                            prog_a            = entry_program_reg;
                            pid_a             = entry_pid_next;
                            entries_left_next = entries_dec;
                            if (entries_dec == 10'd0)
                                phase_next = ts_pat_pkg::PH_CRC;
                        end
                    endcase
                    byte_in_field_next = byte_in_field_reg + 2'd1;
                end
                ts_pat_pkg::PH_CRC:
                begin
                    crc_next = {crc_reg[23:0], data_byte};
                    if (byte_in_field_reg == 2'd3)
                    begin
                        has_a      = 1'b1;
                        kind_a     = ts_pat_pkg::KIND_DONE;
                        crc_a      = crc_next;
                        phase_next = ts_pat_pkg::PH_IDLE;
                    end
                    byte_in_field_next = byte_in_field_reg + 2'd1;
                end
                default:
                begin
                    phase_next = ts_pat_pkg::PH_IDLE;
                    skip       = 1'b1;
                end
            endcase
        end

        has_trunc = !skip && buffer_end && (phase_next != ts_pat_pkg::PH_IDLE);
        if (has_trunc)
            phase_next = ts_pat_pkg::PH_IDLE;

        base_res.kind               = ts_pat_pkg::KIND_TRUNCATED;
        base_res.program_number     = 16'd0;
        base_res.map_pid            = 13'd0;
        base_res.stream_id          = stream_id_next;
        base_res.version            = version_next;
        base_res.current_next       = current_bit_next;
        base_res.section_index      = section_next;
        base_res.last_section_index = last_section_next;
        base_res.crc_value          = 32'd0;
        base_res.entry_total        = ts_pat_pkg::total_entries(length_field_next);
        base_res.last_of_run        = 1'b1;

        res_a                = base_res;
        res_a.kind           = kind_a;
        res_a.program_number = prog_a;
        res_a.map_pid        = pid_a;
        res_a.crc_value      = crc_a;
        res_a.last_of_run    = !has_trunc;

        res_t0 = base_res;

        slot0 = has_a ? res_a : res_t0;
        slot1 = res_t0;
        n_res = {1'b0, has_a} + {1'b0, has_trunc};
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (in_accept)
        begin
            wr_ptr_next = wr_ptr_reg + n_res;
            count_next  = count_reg + {1'b0, n_res};
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 2'd1;
            count_next  = count_next - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= ts_pat_pkg::PH_IDLE;
            byte_in_field_reg <= 2'd0;
            entries_left_reg  <= 10'd0;
            length_field_reg  <= 12'd0;
            entry_program_reg <= 16'd0;
            entry_pid_reg     <= 13'd0;
            stream_id_reg     <= 16'd0;
            version_reg       <= 5'd0;
            current_bit_reg   <= 1'b0;
            section_reg       <= 8'd0;
            last_section_reg  <= 8'd0;
            crc_reg           <= 32'd0;
            wr_ptr_reg        <= '0;
            rd_ptr_reg        <= '0;
            count_reg         <= '0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg         <= phase_next;
                byte_in_field_reg <= byte_in_field_next;
                entries_left_reg  <= entries_left_next;
                length_field_reg  <= length_field_next;
                entry_program_reg <= entry_program_next;
                entry_pid_reg     <= entry_pid_next;
                stream_id_reg     <= stream_id_next;
                version_reg       <= version_next;
                current_bit_reg   <= current_bit_next;
                section_reg       <= section_next;
                last_section_reg  <= last_section_next;
                crc_reg           <= crc_next;
            end
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && (n_res != 2'd0))
            fifo_reg[wr_ptr_reg] <= slot0;
        if (in_accept && (n_res == 2'd2))
            fifo_reg[wr_ptr_reg + 2'd1] <= slot1;
    end

    assign result_kind        = fifo_reg[rd_ptr_reg].kind;
    assign program_number     = fifo_reg[rd_ptr_reg].program_number;
    assign map_pid            = fifo_reg[rd_ptr_reg].map_pid;
    assign stream_id          = fifo_reg[rd_ptr_reg].stream_id;
    assign version            = fifo_reg[rd_ptr_reg].version;
    assign current_next       = fifo_reg[rd_ptr_reg].current_next;
    assign section_index      = fifo_reg[rd_ptr_reg].section_index;
    assign last_section_index = fifo_reg[rd_ptr_reg].last_section_index;
    assign crc_value          = fifo_reg[rd_ptr_reg].crc_value;
    assign entry_total        = fifo_reg[rd_ptr_reg].entry_total;
    assign last_of_run        = fifo_reg[rd_ptr_reg].last_of_run;

endmodule
